### rtl/wstc_pkg.sv
// Shared constants for the weighted step time counter.
// No dependencies.
package wstc_pkg;
    localparam int MAX_STEPS_DEF = 16;
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_RUN   = 3'd1;
    localparam logic [2:0] OP_RESET = 3'd2;
    localparam logic [2:0] OP_SYNC  = 3'd3;
    localparam logic [2:0] OP_LIMIT = 3'd4;
    localparam logic [2:0] CFG_MIN   = 3'd0;
    localparam logic [2:0] CFG_MAX   = 3'd1;
    localparam logic [2:0] CFG_STEP  = 3'd2;
    localparam logic [2:0] CFG_CYCLE = 3'd3;
    localparam logic [2:0] CFG_DUTY  = 3'd4;
endpackage

### rtl/wstc_div.sv
// Restoring serial divider, one quotient bit per cycle, 64 by 33 bits.
// Depends on nothing.
module wstc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [32:0] o_rem
);
    logic [63:0] r_q;
    logic [33:0] r_r;
    logic [32:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_sh;
    logic [34:0] w_sub;

    assign w_sh  = {r_r[32:0], r_q[63]};
    assign w_sub = {1'b0, w_sh} - {2'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= i_num;
                r_r    <= '0;
                r_d    <= i_den;
            end else if (r_busy) begin
                if (!w_sub[34]) begin
                    r_r <= w_sub[33:0];
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_r <= w_sh;
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r[32:0];
endmodule

### rtl/weighted_step_time_counter.sv
// Weighted step time counter top level with sequencer and limit memory.
// Depends on wstc_pkg and wstc_div.
//
// Usage: items enter on the s_axis group, op in tuser, fields in tdata.
// Every item yields exactly one result on m_axis. Configuration is written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only while
// the block is idle, which the block itself does not enforce. Pause, a run
// flag that changes nothing, a tick while paused, limit write, sync and
// unused ops present their result in the cycle after acceptance. Other
// items pass through the 64-step serial divider. In slice mode a tick or a
// resume first takes its phase modulo the cycle if it wraps, then divides
// for the step count and for the slice; a reset value divides for the step
// count, its slice and its phase. In duty mode the slice division becomes a
// walk over the limits, and a reset value reads its phase from limit memory.
// The block holds one item at a time; s_axis tready is high only when it is
// idle and the result register is empty. A result waits in the output
// register while m_axis tready is low, and no item is accepted meanwhile.
// Reset clears the phase and the run state and restores the configuration
// to its defaults; limit memory entries are undefined until written.
module weighted_step_time_counter #(
    parameter int MAX_STEPS = wstc_pkg::MAX_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: run_flag[0], reset_value[16:1], limit_index[20:17],
    // limit_ticks[52:21], zero fill to 56 bits
    input  logic [55:0] s_axis_tdata,
    // tuser: op[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: count_value[15:0], value_changed[16], cycle_sync[17], zero fill
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import wstc_pkg::*;
    localparam int IW = $clog2(MAX_STEPS);

    localparam logic [3:0] S_IDLE = 4'd0, S_NDIV = 4'd1, S_NWAIT = 4'd2,
        S_DISP = 4'd3, S_KDIV = 4'd4, S_KWAIT = 4'd5, S_WALK = 4'd6,
        S_WCHK = 4'd7, S_FORM = 4'd8, S_SDIV = 4'd9, S_SWAIT = 4'd10,
        S_PHASE = 4'd11, S_RDL = 4'd12, S_RWAIT = 4'd13, S_MDIV = 4'd14,
        S_MWAIT = 4'd15;

    logic signed [15:0] r_min, r_max;
    logic [14:0] r_step;
    logic [31:0] r_cycle;
    logic        r_duty;
    logic [3:0]  r_st;
    logic [31:0] r_phase;
    logic        r_paused, r_first;
    logic signed [15:0] r_cur;
    logic [2:0]  r_op;
    logic signed [15:0] r_rv;
    logic        r_sync;
    logic [16:0] r_n;
    logic [16:0] r_k;
    logic [16:0] r_s;
    logic [IW:0] r_i;
    logic        r_ovalid;
    logic [17:0] r_odata;
    logic [31:0] r_mem [MAX_STEPS];
    logic [31:0] r_rd;
    logic [32:0] r_wnum;

    logic signed [15:0] w_emax;
    logic [14:0] w_step;
    logic [32:0] w_cyc;
    logic [16:0] w_walk;
    logic        w_start;
    logic [63:0] w_num, w_quo;
    logic [32:0] w_den, w_rem;
    logic        w_done;
    logic [32:0] w_p1;
    logic signed [15:0] w_cl;
    logic signed [31:0] w_v;
    logic [2:0]  w_op;
    logic [3:0]  w_li;

    assign w_op   = s_axis_tuser;
    assign w_li   = s_axis_tdata[20:17];
    assign w_emax = (r_max < r_min) ? r_min : r_max;
    assign w_step = (r_step == 15'd0) ? 15'd1 : r_step;
    assign w_cyc  = (r_cycle == 32'd0) ? 33'd1 : {1'b0, r_cycle};
    assign w_walk = (r_n < 17'(MAX_STEPS)) ? r_n : 17'(MAX_STEPS);
    assign w_p1   = {1'b0, r_phase} + 33'd1;
    assign w_cl   = (r_rv < r_min) ? r_min : ((r_rv > w_emax) ? w_emax : r_rv);
    assign w_v    = 32'(r_min) + $signed({15'd0, 17'(r_k * 17'(w_step))});

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odata};

    wstc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_done),
        .o_quo(w_quo), .o_rem(w_rem)
    );

    always_comb begin
        w_start = 1'b0;
        w_num   = '0;
        w_den   = 33'd1;
        unique case (r_st)
            S_PHASE: begin
                w_start = 1'b1;
                w_num = {31'd0, r_wnum};
                w_den = w_cyc;
            end
            S_NDIV: begin
                w_start = 1'b1;
                w_num = {48'd0, 16'(w_emax - r_min)};
                w_den = {18'd0, w_step};
            end
            S_KDIV: begin
                w_start = 1'b1;
                w_num = 64'(r_phase) * 64'(r_n);
                w_den = w_cyc;
            end
            S_SDIV: begin
                w_start = 1'b1;
                w_num = {48'd0, 16'(w_cl - r_min)};
                w_den = {18'd0, w_step};
            end
            S_MDIV: begin
                w_start = 1'b1;
                w_num = 64'(r_s) * 64'(w_cyc);
                w_den = {16'd0, r_n};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE) r_wnum <= (w_op == OP_TICK) ? w_p1 : {1'b0, r_phase};
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_i[IW-1:0]];
        if (r_st == S_IDLE && s_axis_tvalid && s_axis_tready && w_op == OP_LIMIT
            && 32'(w_li) < MAX_STEPS)
            r_mem[IW'(w_li)] <= s_axis_tdata[52:21];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 16'sd0; r_max <= 16'sd1; r_step <= 15'd1;
            r_cycle <= 32'd1000; r_duty <= 1'b0;
            r_st <= S_IDLE; r_phase <= '0; r_paused <= 1'b0;
            r_cur <= '0; r_first <= 1'b1; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN:   r_min <= i_cfg_data[15:0];
                    CFG_MAX:   r_max <= i_cfg_data[15:0];
                    CFG_STEP:  r_step <= i_cfg_data[14:0];
                    CFG_CYCLE: r_cycle <= i_cfg_data;
                    CFG_DUTY:  r_duty <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_op <= w_op;
                    r_rv <= s_axis_tdata[16:1];
                    case (w_op)
                        OP_TICK: if (r_paused) begin
                            r_ovalid <= 1'b1; r_odata <= {2'b00, r_cur};
                        end else if (w_p1 > w_cyc) begin
                            r_sync <= 1'b1;
                            r_st <= S_PHASE;
                        end else begin
                            r_sync <= 1'b0;
                            r_phase <= w_p1[31:0];
                            r_st <= S_NDIV;
                        end
                        OP_RUN: if (!s_axis_tdata[0] || !r_paused) begin
                            if (!s_axis_tdata[0]) r_paused <= 1'b1;
                            r_ovalid <= 1'b1; r_odata <= {2'b00, r_cur};
                        end else begin
                            r_paused <= 1'b0;
                            r_sync <= ({1'b0, r_phase} > w_cyc);
                            r_st <= ({1'b0, r_phase} > w_cyc) ? S_PHASE : S_NDIV;
                        end
                        OP_RESET: begin
                            r_sync <= 1'b0;
                            r_st <= S_NDIV;
                        end
                        OP_SYNC: begin
                            r_phase <= '0;
                            r_ovalid <= 1'b1;
                            r_odata <= {1'b0, (r_min != r_cur) || r_first, r_min};
                            r_first <= 1'b0; r_cur <= r_min;
                        end
                        default: begin
                            r_ovalid <= 1'b1; r_odata <= {2'b00, r_cur};
                        end
                    endcase
                end
                S_PHASE: begin
                    // Wrap: phase modulo cycle through the divider.
                    r_st <= S_RWAIT;
                end
                S_RWAIT: if (w_done) begin
                    r_phase <= w_rem[31:0];
                    r_st <= S_NDIV;
                end
                S_NDIV: r_st <= S_NWAIT;
                S_NWAIT: if (w_done) begin
                    r_n <= w_quo[16:0] + 17'd1;
                    r_st <= S_DISP;
                end
                S_DISP: begin
                    r_i <= '0;
                    if (r_op == OP_RESET) r_st <= S_SDIV;
                    else if (r_duty) r_st <= S_WALK;
                    else r_st <= S_KDIV;
                end
                S_KDIV: r_st <= S_KWAIT;
                S_KWAIT: if (w_done) begin
                    r_k <= (w_quo > 64'(r_n)) ? r_n : w_quo[16:0];
                    r_st <= S_FORM;
                end
                S_WALK: begin
                    if (17'(r_i) >= w_walk) begin
                        r_k <= w_walk;
                        r_st <= S_FORM;
                    end else r_st <= S_WCHK;
                end
                S_WCHK: begin
                    if (r_phase <= r_rd) begin
                        r_k <= 17'(r_i);
                        r_st <= S_FORM;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_st <= S_WALK;
                    end
                end
                S_FORM: begin
                    logic signed [15:0] v;
                    v = (w_v > 32'(w_emax)) ? w_emax : w_v[15:0];
                    r_ovalid <= 1'b1;
                    r_odata <= {r_sync, (v != r_cur) || r_first, v};
                    r_first <= 1'b0; r_cur <= v; r_st <= S_IDLE;
                end
                S_SDIV: r_st <= S_SWAIT;
                S_SWAIT: if (w_done) begin
                    r_s <= w_quo[16:0];
                    r_k <= w_quo[16:0];
                    r_i <= (w_quo[16:0] < 17'(MAX_STEPS)) ? (IW+1)'(w_quo[16:0])
                                                          : (IW+1)'(MAX_STEPS - 1);
                    r_st <= r_duty ? S_RDL : S_MDIV;
                end
                S_RDL: r_st <= S_MWAIT;
                S_MDIV: r_st <= S_MWAIT;
                S_MWAIT: if (r_duty || w_done) begin
                    r_phase <= r_duty ? r_rd : w_quo[31:0];
                    r_st <= S_FORM;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input open while a result waits");
    a_wrap_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RWAIT && w_done) |-> (w_rem < w_cyc))
        else $error("wrap remainder out of range");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FORM) |-> (r_k <= r_n))
        else $error("step index above step count");
endmodule
